>>> rtl/phrp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the pixel hit record parser.
// No dependencies.
package phrp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 15;
  localparam int unsigned ColW   = 13;
  localparam int unsigned RowW   = 9;
  // Hit code is (b0 << 14) + (b1 << 7) + b2.
  localparam int unsigned CodeW  = 23;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_HIT    = 2'd1,
    KIND_TRUNC  = 2'd2
  } record_kind_t;

endpackage

>>> rtl/pixel_hit_record_parser.sv
`timescale 1ns / 1ps
// Top level of the pixel hit record parser: byte-stream parser with a result register.
// Depends on phrp_pkg.
//
// Takes one byte per cycle and gives at most one result per byte, in the cycle after
// the byte is accepted. The parse state (phase, plane, count, hit bytes) is updated
// by short logic in the accept cycle, and the result lands in one output register.
// in_stall rises only while that register holds a result that the consumer stalls,
// so with out_stall low the block sustains one byte per clock. A block_end inside a
// record yields a truncation result and returns the parser to its reset state.
module pixel_hit_record_parser (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [phrp_pkg::ByteW-1:0]        data_byte,
  input  logic                              block_end,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        record_kind,
  output logic [phrp_pkg::ByteW-1:0]        plane_id,
  output logic [phrp_pkg::CountW-1:0]       hit_count,
  output logic [phrp_pkg::CountW-1:0]       hit_index,
  output logic [phrp_pkg::ColW-1:0]         column,
  output logic [phrp_pkg::RowW-1:0]         row,
  output logic                              last_hit,
  output logic                              end_of_block
);
  import phrp_pkg::*;

  typedef enum logic [2:0] {
    PH_PLANE    = 3'd0,
    PH_COUNT    = 3'd1,
    PH_COUNT_LO = 3'd2,
    PH_HIT0     = 3'd3,
    PH_HIT1     = 3'd4,
    PH_HIT2     = 3'd5
  } phase_t;

  phase_t              phase, phase_next;
  logic [ByteW-1:0]    current_plane, current_plane_next;
  logic [6:0]          count_high, count_high_next;
  logic [CountW-1:0]   hits_total, hits_total_next;
  logic [CountW-1:0]   hits_done, hits_done_next;
  logic [ByteW-1:0]    hit_byte_first, hit_byte_first_next;
  logic [ByteW-1:0]    hit_byte_second, hit_byte_second_next;

  logic                res_valid;
  record_kind_t        res_kind;
  logic [CountW-1:0]   res_index;
  logic [ColW-1:0]     res_col;
  logic [RowW-1:0]     res_row;
  logic                res_last;
  logic                res_eob;
  logic [ByteW-1:0]    res_plane;
  logic [CountW-1:0]   res_count;

  logic                header;
  logic                complete;
  logic                hit_last;
  logic [CodeW-1:0]    code;
  logic                in_accept;

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  assign code = ({{(CodeW-ByteW){1'b0}}, hit_byte_first} << 14)
              + ({{(CodeW-ByteW){1'b0}}, hit_byte_second} << 7)
              + {{(CodeW-ByteW){1'b0}}, data_byte};
  assign hit_last = ({1'b0, hits_done} + {{CountW{1'b0}}, 1'b1}) == {1'b0, hits_total};

  always_comb begin
    phase_next           = phase;
    current_plane_next   = current_plane;
    count_high_next      = count_high;
    hits_total_next      = hits_total;
    hits_done_next       = hits_done;
    hit_byte_first_next  = hit_byte_first;
    hit_byte_second_next = hit_byte_second;
    res_valid = 1'b0;
    res_kind  = KIND_HEADER;
    res_index = '0;
    res_col   = '0;
    res_row   = '0;
    res_last  = 1'b0;
    res_eob   = 1'b0;
    res_plane = '0;
    res_count = '0;
    header    = 1'b0;
    complete  = 1'b0;

    unique case (phase)
      PH_COUNT: begin
        if (data_byte[7]) begin
          count_high_next = data_byte[6:0];
          phase_next      = PH_COUNT_LO;
        end else begin
          hits_total_next = {{(CountW-ByteW){1'b0}}, data_byte};
          header          = 1'b1;
        end
      end
      PH_COUNT_LO: begin
        hits_total_next = {count_high, data_byte};
        header          = 1'b1;
      end
      PH_HIT0: begin
        hit_byte_first_next = data_byte;
        phase_next          = PH_HIT1;
      end
      PH_HIT1: begin
        hit_byte_second_next = data_byte;
        phase_next           = PH_HIT2;
      end
      PH_HIT2: begin
        res_valid      = 1'b1;
        res_kind       = KIND_HIT;
        res_index      = hits_done;
        res_col        = code[RowW+ColW-1:RowW];
        res_row        = code[RowW-1:0];
        res_last       = hit_last;
        hits_done_next = hits_done + {{(CountW-1){1'b0}}, 1'b1};
        if (hit_last) begin
          complete   = 1'b1;
          phase_next = PH_PLANE;
        end else begin
          phase_next = PH_HIT0;
        end
      end
      default: begin
        // Unused phase codes act as the plane-id phase.
        current_plane_next = data_byte;
        count_high_next    = '0;
        hits_total_next    = '0;
        hits_done_next     = '0;
        phase_next         = PH_COUNT;
      end
    endcase

    if (header) begin
      res_valid      = 1'b1;
      res_kind       = KIND_HEADER;
      res_index      = '0;
      res_last       = (hits_total_next == '0);
      hits_done_next = '0;
      if (hits_total_next == '0) begin
        complete   = 1'b1;
        phase_next = PH_PLANE;
      end else begin
        phase_next = PH_HIT0;
      end
    end

    res_plane = current_plane_next;
    res_count = hits_total_next;

    if (block_end) begin
      if (complete) begin
        res_eob = 1'b1;
      end else begin
        // Drop any partial result, report the truncation, then start over.
        res_valid = 1'b1;
        res_kind  = KIND_TRUNC;
        res_index = hits_done_next;
        res_col   = '0;
        res_row   = '0;
        res_last  = 1'b0;
        res_eob   = 1'b1;
        phase_next           = PH_PLANE;
        current_plane_next   = '0;
        count_high_next      = '0;
        hits_total_next      = '0;
        hits_done_next       = '0;
        hit_byte_first_next  = '0;
        hit_byte_second_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_PLANE;
      current_plane   <= '0;
      count_high      <= '0;
      hits_total      <= '0;
      hits_done       <= '0;
      hit_byte_first  <= '0;
      hit_byte_second <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (in_accept) begin
        phase           <= phase_next;
        current_plane   <= current_plane_next;
        count_high      <= count_high_next;
        hits_total      <= hits_total_next;
        hits_done       <= hits_done_next;
        hit_byte_first  <= hit_byte_first_next;
        hit_byte_second <= hit_byte_second_next;
        out_valid       <= res_valid;
        // Result payload: load only on an accepted byte, hold otherwise.
        record_kind     <= res_kind;
        plane_id        <= res_plane;
        hit_count       <= res_count;
        hit_index       <= res_index;
        column          <= res_col;
        row             <= res_row;
        last_hit        <= res_last;
        end_of_block    <= res_eob;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_trunc_ends_block: assert property (@(posedge clk) disable iff (rst)
    out_valid && record_kind == KIND_TRUNC |-> end_of_block && !last_hit)
    else $error("truncation result without end of block");

  a_hit_index_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && record_kind == KIND_HIT |-> hit_index < hit_count)
    else $error("hit index beyond announced count");

  a_block_end_restarts: assert property (@(posedge clk) disable iff (rst)
    in_accept && block_end |=> phase == PH_PLANE)
    else $error("parser not at plane id after block end");

  a_reset_clears_out: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for pixel_hit_record_parser: byte stream in, parsed records out.
// Depends on phrp_pkg and the parser RTL; a scoreboard class predicts every record.
module tb;
  import phrp_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 300;

  typedef enum logic [2:0] {
    WANT_PLANE    = 3'd0,
    WANT_COUNT    = 3'd1,
    WANT_COUNT_LO = 3'd2,
    WANT_HIT_B0   = 3'd3,
    WANT_HIT_B1   = 3'd4,
    WANT_HIT_B2   = 3'd5
  } parse_phase_t;

  typedef struct packed {
    record_kind_t        kind;
    logic [ByteW-1:0]    plane;
    logic [CountW-1:0]   count;
    logic [CountW-1:0]   index;
    logic [ColW-1:0]     column;
    logic [RowW-1:0]     row;
    logic                last;
    logic                eob;
  } parsed_record_t;

  class record_checker;
    parse_phase_t      phase;
    logic [ByteW-1:0]  plane;
    logic [6:0]        count_hi;
    logic [CountW-1:0] total;
    logic [CountW-1:0] done_hits;
    logic [ByteW-1:0]  hit_b0;
    logic [ByteW-1:0]  hit_b1;
    parsed_record_t    expected_records[$];
    int unsigned       errors;
    int unsigned       checked;

    function new();
      clear_state();
      errors = 0;
      checked = 0;
    endfunction

    function void clear_state();
      phase = WANT_PLANE;
      plane = '0;
      count_hi = '0;
      total = '0;
      done_hits = '0;
      hit_b0 = '0;
      hit_b1 = '0;
    endfunction

    function parsed_record_t make_record(record_kind_t kind, logic [CountW-1:0] index,
                                         logic [ColW-1:0] col, logic [RowW-1:0] r,
                                         logic last, logic eob);
      parsed_record_t rec;
      rec.kind = kind;
      rec.plane = plane;
      rec.count = total;
      rec.index = index;
      rec.column = col;
      rec.row = r;
      rec.last = last;
      rec.eob = eob;
      return rec;
    endfunction

    // Advance the parse state by one accepted byte and queue the record it yields.
    function void take_byte(logic [ByteW-1:0] b, logic fin);
      parsed_record_t rec;
      logic           have;
      logic           complete;
      logic           header;
      logic           last;
      logic [23:0]    code;
      have = 1'b0;
      complete = 1'b0;
      header = 1'b0;
      case (phase)
        WANT_COUNT: begin
          if (b[7]) begin
            count_hi = b[6:0];
            phase = WANT_COUNT_LO;
          end else begin
            total = {7'd0, b};
            header = 1'b1;
          end
        end
        WANT_COUNT_LO: begin
          total = {count_hi, b};
          header = 1'b1;
        end
        WANT_HIT_B0: begin
          hit_b0 = b;
          phase = WANT_HIT_B1;
        end
        WANT_HIT_B1: begin
          hit_b1 = b;
          phase = WANT_HIT_B2;
        end
        WANT_HIT_B2: begin
          // The three 7-bit shifts overlap, so add rather than concatenate.
          code = ({16'd0, hit_b0} << 14) + ({16'd0, hit_b1} << 7) + {16'd0, b};
          last = (({1'b0, done_hits} + 16'd1) == {1'b0, total});
          rec = make_record(KIND_HIT, done_hits, code[21:9], code[8:0], last, 1'b0);
          have = 1'b1;
          done_hits = done_hits + 15'd1;
          if (last) begin
            complete = 1'b1;
            phase = WANT_PLANE;
          end else begin
            phase = WANT_HIT_B0;
          end
        end
        default: begin
          plane = b;
          count_hi = '0;
          total = '0;
          done_hits = '0;
          phase = WANT_COUNT;
        end
      endcase

      if (header) begin
        rec = make_record(KIND_HEADER, '0, '0, '0, total == '0, 1'b0);
        have = 1'b1;
        done_hits = '0;
        if (total == '0) begin
          complete = 1'b1;
          phase = WANT_PLANE;
        end else begin
          phase = WANT_HIT_B0;
        end
      end

      if (fin) begin
        if (complete) begin
          rec.eob = 1'b1;
        end else begin
          // Drop whatever this byte produced and report the cut record instead.
          rec = make_record(KIND_TRUNC, done_hits, '0, '0, 1'b0, 1'b1);
          have = 1'b1;
          clear_state();
        end
      end

      if (have) expected_records.push_back(rec);
    endfunction

    function int unsigned pending();
      return expected_records.size();
    endfunction

    function string show(parsed_record_t r);
      return $sformatf("kind %0d plane %02h count %0d index %0d col %0d row %0d last %b eob %b",
                       r.kind, r.plane, r.count, r.index, r.column, r.row, r.last, r.eob);
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    task check_record(parsed_record_t got);
      parsed_record_t want;
      checked++;
      if (expected_records.size() == 0) begin
        report($sformatf("record %0d not expected: %s", checked, show(got)));
      end else begin
        want = expected_records.pop_front();
        if (got.kind !== want.kind || got.plane !== want.plane ||
            got.count !== want.count || got.index !== want.index ||
            got.column !== want.column || got.row !== want.row ||
            got.last !== want.last || got.eob !== want.eob)
          report($sformatf("record %0d got %s / want %s", checked, show(got), show(want)));
      end
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [ByteW-1:0]    data_byte = '0;
  logic                block_end = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          record_kind;
  logic [ByteW-1:0]    plane_id;
  logic [CountW-1:0]   hit_count;
  logic [CountW-1:0]   hit_index;
  logic [ColW-1:0]     column;
  logic [RowW-1:0]     row;
  logic                last_hit;
  logic                end_of_block;

  record_checker  sb;
  parsed_record_t seen;
  logic           in_gaps = 1'b1;
  logic           out_gaps = 1'b1;
  logic           stress_hold = 1'b0;
  logic           hold_done = 1'b0;
  int unsigned    hold_left = 0;
  int unsigned    sent_bytes = 0;
  int unsigned    byte_goal = 0;
  int unsigned    cycle_count = 0;

  pixel_hit_record_parser DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .block_end    (block_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .record_kind  (record_kind),
    .plane_id     (plane_id),
    .hit_count    (hit_count),
    .hit_index    (hit_index),
    .column       (column),
    .row          (row),
    .last_hit     (last_hit),
    .end_of_block (end_of_block)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Accepted input bytes feed the predictor; accepted results are checked.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.take_byte(data_byte, block_end);
      if (out_valid && !out_stall) begin
        seen.kind = record_kind_t'(record_kind);
        seen.plane = plane_id;
        seen.count = hit_count;
        seen.index = hit_index;
        seen.column = column;
        seen.row = row;
        seen.last = last_hit;
        seen.eob = end_of_block;
        sb.check_record(seen);
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off while the sender keeps going.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (stress_hold && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else begin
      out_stall <= out_gaps && ($urandom_range(0, 99) < 35);
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("pixel_hit_record_parser test failed");
    $finish;
  end

  // Called and left at a falling edge; valid stays high for back-to-back bytes.
  task automatic send_byte(input logic [ByteW-1:0] b, input logic fin);
    while (in_gaps && $urandom_range(0, 99) < 35) begin
      in_valid <= 1'b0;
      data_byte <= 8'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    block_end <= fin;
    sent_bytes++;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Hold the sender until every predicted record has come out.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  task automatic run_directed();
    // zero-hit header, block ends on it
    send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b1);
    // all-ones hit: column wraps at 13 bits
    send_byte(8'hFF, 1'b0); send_byte(8'h01, 1'b0);
    send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0);
    // two-byte count of 2, final hit ends the block
    send_byte(8'hA5, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'h02, 1'b0);
    send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'h01, 1'b1);
    // two-byte count of zero with block end on the low byte
    send_byte(8'h12, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'h00, 1'b1);
    // cut on the plane byte, then on the high count byte
    send_byte(8'h33, 1'b1);
    send_byte(8'h44, 1'b0); send_byte(8'hFF, 1'b1);
    // largest count, cut on the third byte of a non-final hit
    send_byte(8'h77, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0); send_byte(8'h02, 1'b0); send_byte(8'h03, 1'b1);
  endtask

  // Mostly well-formed records with random content; some cut short, some noise.
  task automatic send_random_record();
    logic [ByteW-1:0] rec[$];
    int unsigned      mode;
    int unsigned      pick;
    int unsigned      n_hits;
    int unsigned      cut;
    logic             big;
    mode = $urandom_range(0, 99);
    if (mode < 8) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
      return;
    end
    big = 1'b0;
    rec.push_back(8'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      n_hits = 0;
      rec.push_back(8'h00);
    end else if (pick < 65) begin
      n_hits = $urandom_range(1, 6);
      rec.push_back(8'(n_hits));
    end else if (pick < 75) begin
      n_hits = $urandom_range(7, 40);
      rec.push_back(8'(n_hits));
    end else if (pick < 88) begin
      n_hits = $urandom_range(0, 8);
      rec.push_back(8'h80);
      rec.push_back(8'(n_hits));
    end else begin
      // count too large to finish here: always cut
      big = 1'b1;
      n_hits = $urandom_range(0, 3);
      rec.push_back(8'h80 | 8'($urandom_range(1, 127)));
      rec.push_back(8'($urandom));
    end
    repeat (n_hits * 3) rec.push_back(8'($urandom));

    if (big || mode < 25) begin
      cut = big ? $urandom_range(0, rec.size() - 1) : $urandom_range(0, rec.size() - 2);
      for (int i = 0; i <= int'(cut); i++) send_byte(rec[i], i == int'(cut));
    end else begin
      for (int i = 0; i < rec.size(); i++)
        send_byte(rec[i], mode < 40 && i == rec.size() - 1);
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();
    drain();

    while (sent_bytes < 280) send_random_record();
    // long receiver hold-off while bytes keep coming
    stress_hold = 1'b1;
    byte_goal = sent_bytes + 80;
    while (sent_bytes < byte_goal) send_random_record();
    drain();

    in_gaps = 1'b0;
    out_gaps = 1'b0;
    while (sent_bytes < 480) send_random_record();
    in_gaps = 1'b1;
    out_gaps = 1'b1;
    while (sent_bytes < 730) send_random_record();

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0)
      $display("pixel_hit_record_parser test passed");
    else
      $display("pixel_hit_record_parser test failed");
    $finish;
  end

endmodule
